>>> rtl/sorted_priority_queue_core_defines.svh
// assertion macros used by the sorted priority queue sequencer rtl
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/spq_pkg.sv
// package: sizes, codes, shared types and pointer helpers for the queue
`timescale 1ns / 1ps

package spq_pkg;

  // sizing
  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 10;
  localparam int TAG_BITS = 8;
  localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } spq_status_t;

  // one result transaction
  typedef struct packed {
    spq_status_t         status;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
    logic [CNT_W-1:0]    count;
  } spq_result_t;

  // store write port
  typedef struct packed {
    logic                en;
    logic [PTR_W-1:0]    addr;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } spq_wr_t;

  // store read port
  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
  } spq_rd_t;

  // ring pointer one slot back
  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == '0) begin
      r = PTR_W'(CAPACITY - 1);
    end else begin
      r = p - PTR_W'(1);
    end
    return r;
  endfunction

  // ring pointer one slot on
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // ring pointer advanced by an entry count
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] n);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(p) + (CNT_W + 1)'(n);
    if (sum >= (CNT_W + 1)'(CAPACITY)) begin
      sum = sum - (CNT_W + 1)'(CAPACITY);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

>>> rtl/spq_ifs.sv
// interfaces: command channel and result channel of the queue
`timescale 1ns / 1ps

interface spq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [spq_pkg::KEY_BITS-1:0] key_in;
  logic [spq_pkg::TAG_BITS-1:0] tag_in;

  modport source (output valid, output cmd, output key_in, output tag_in, input ready);
  modport sink   (input valid, input cmd, input key_in, input tag_in, output ready);
endinterface

interface spq_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [spq_pkg::KEY_BITS-1:0] key_out;
  logic [spq_pkg::TAG_BITS-1:0] tag_out;
  logic [spq_pkg::CNT_W-1:0]    count;

  modport source (output valid, output status, output key_out, output tag_out,
                  output count, input ready);
  modport sink   (input valid, input status, input key_out, input tag_out,
                  input count, output ready);
endinterface

>>> rtl/sorted_priority_queue_core.sv
// Sorted priority queue of up to 16 (key, tag) entries, highest key served first and
// equal keys first-in first-out. Entries sit in a ring store with a head pointer, so a
// dequeue pops the head: S_READ reads it, S_CMP moves the head on, S_RES holds the result.
// An enqueue walks from the tail towards the head through the single store read port and
// one key comparator, moving each entry with a smaller key one slot towards the tail
// (read in S_READ, compared and rewritten in S_CMP); it ends at the head, or stops
// behind an entry with an equal or larger key. Dequeue on an empty queue and enqueue
// on a full one skip the store. in_chan.ready comes back at the same edge that loads the
// result into the output register, which holds it until out_chan.ready takes it.
`timescale 1ns / 1ps

module sorted_priority_queue_core (
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_chan,
  spq_out_if.source  out_chan
);

  spq_pkg::spq_wr_t             wr;
  spq_pkg::spq_rd_t             rd;
  logic [spq_pkg::KEY_BITS-1:0] rd_key;
  logic [spq_pkg::TAG_BITS-1:0] rd_tag;
  logic                         res_valid;
  spq_pkg::spq_result_t         res;
  logic                         out_free;
  logic                         out_valid_r, out_valid_nxt;
  spq_pkg::spq_result_t         out_res_r;

  spq_store u_store (
    .clk    (clk),
    .wr     (wr),
    .rd     (rd),
    .rd_key (rd_key),
    .rd_tag (rd_tag)
  );

  spq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .wr        (wr),
    .rd        (rd),
    .rd_key    (rd_key),
    .rd_tag    (rd_tag)
  );

  // output register: free when empty or being taken this cycle
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_res_r <= res;
    end
  end

  // result transaction
  assign out_chan.valid   = out_valid_r;
  assign out_chan.status  = out_res_r.status;
  assign out_chan.key_out = out_res_r.key;
  assign out_chan.tag_out = out_res_r.tag;
  assign out_chan.count   = out_res_r.count;

endmodule

>>> rtl/spq_store.sv
// entry store: ring of keys and tags, one write and one registered read a cycle
`timescale 1ns / 1ps

module spq_store (
  input  logic                          clk,
  input  spq_pkg::spq_wr_t              wr,
  input  spq_pkg::spq_rd_t              rd,
  output logic [spq_pkg::KEY_BITS-1:0]  rd_key,
  output logic [spq_pkg::TAG_BITS-1:0]  rd_tag
);

  logic [spq_pkg::KEY_BITS-1:0] key_mem [spq_pkg::CAPACITY];
  logic [spq_pkg::TAG_BITS-1:0] tag_mem [spq_pkg::CAPACITY];
  logic [spq_pkg::KEY_BITS-1:0] rd_key_r;
  logic [spq_pkg::TAG_BITS-1:0] rd_tag_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr.addr] <= wr.key;
      tag_mem[wr.addr] <= wr.tag;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_key_r <= key_mem[rd.addr];
      rd_tag_r <= tag_mem[rd.addr];
    end
  end

  assign rd_key = rd_key_r;
  assign rd_tag = rd_tag_r;

endmodule

>>> rtl/spq_seq.sv
// sequencer: insertion walk with one shared key comparator, head pop, result build
`timescale 1ns / 1ps

`include "sorted_priority_queue_core_defines.svh"

module spq_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  spq_in_if.sink                        in_chan,
  input  logic                          out_free,
  output logic                          res_valid,
  output spq_pkg::spq_result_t          res,
  output spq_pkg::spq_wr_t              wr,
  output spq_pkg::spq_rd_t              rd,
  input  logic [spq_pkg::KEY_BITS-1:0]  rd_key,
  input  logic [spq_pkg::TAG_BITS-1:0]  rd_tag
);

  localparam int PTR_W = spq_pkg::PTR_W;
  localparam int CNT_W = spq_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_RES  = 4'b1000
  } state_t;

  state_t                       state_r,   state_nxt;
  logic [PTR_W-1:0]             head_r,    head_nxt;
  logic [CNT_W-1:0]             count_r,   count_nxt;
  logic [CNT_W-1:0]             pos_r,     pos_nxt;
  logic [PTR_W-1:0]             wr_ptr_r,  wr_ptr_nxt;
  logic                         deq_r,     deq_nxt;
  logic [spq_pkg::KEY_BITS-1:0] key_r,     key_nxt;
  logic [spq_pkg::TAG_BITS-1:0] tag_r,     tag_nxt;
  spq_pkg::spq_result_t         res_r,     res_nxt;
  logic                         key_ge;

  // shared comparator: held entry stays ahead when its key is not smaller
  assign key_ge = (rd_key >= key_r);

  assign in_chan.ready = (state_r == S_IDLE);
  assign res_valid     = (state_r == S_RES);
  assign res           = res_r;

  // next-state and datapath control
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    wr_ptr_nxt = wr_ptr_r;
    deq_nxt    = deq_r;
    key_nxt    = key_r;
    tag_nxt    = tag_r;
    res_nxt    = res_r;
    wr         = '0;
    rd         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          key_nxt = in_chan.key_in;
          tag_nxt = in_chan.tag_in;
          deq_nxt = (in_chan.cmd == spq_pkg::CMD_DEQ);
          if (in_chan.cmd == spq_pkg::CMD_DEQ) begin
            if (count_r == '0) begin
              res_nxt   = '{spq_pkg::STATUS_EMPTY, '0, '0, count_r};
              state_nxt = S_RES;
            end else begin
              state_nxt = S_READ;
            end
          end else begin
            if (count_r == CNT_W'(spq_pkg::CAPACITY)) begin
              res_nxt   = '{spq_pkg::STATUS_FULL, '0, '0, count_r};
              state_nxt = S_RES;
            end else begin
              pos_nxt    = count_r;
              wr_ptr_nxt = spq_pkg::ptr_add(head_r, count_r);
              state_nxt  = S_READ;
            end
          end
        end
      end

      S_READ: begin
        if (deq_r) begin
          rd        = '{1'b1, head_r};
          state_nxt = S_CMP;
        end else if (pos_r == '0) begin
          // walked up to the head: new entry becomes the head
          wr        = '{1'b1, wr_ptr_r, key_r, tag_r};
          count_nxt = count_r + CNT_W'(1);
          res_nxt   = '{spq_pkg::STATUS_OK, '0, '0, count_r + CNT_W'(1)};
          state_nxt = S_RES;
        end else begin
          rd        = '{1'b1, spq_pkg::ptr_prev(wr_ptr_r)};
          state_nxt = S_CMP;
        end
      end

      S_CMP: begin
        if (deq_r) begin
          head_nxt  = spq_pkg::ptr_next(head_r);
          count_nxt = count_r - CNT_W'(1);
          res_nxt   = '{spq_pkg::STATUS_OK, rd_key, rd_tag, count_r - CNT_W'(1)};
          state_nxt = S_RES;
        end else if (key_ge) begin
          // slot found behind an equal or larger key
          wr        = '{1'b1, wr_ptr_r, key_r, tag_r};
          count_nxt = count_r + CNT_W'(1);
          res_nxt   = '{spq_pkg::STATUS_OK, '0, '0, count_r + CNT_W'(1)};
          state_nxt = S_RES;
        end else begin
          // smaller key moves one slot towards the tail
          wr         = '{1'b1, wr_ptr_r, rd_key, rd_tag};
          wr_ptr_nxt = spq_pkg::ptr_prev(wr_ptr_r);
          pos_nxt    = pos_r - CNT_W'(1);
          state_nxt  = S_READ;
        end
      end

      S_RES: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    wr_ptr_r <= wr_ptr_nxt;
    deq_r    <= deq_nxt;
    key_r    <= key_nxt;
    tag_r    <= tag_nxt;
    res_r    <= res_nxt;
  end

  // checks
  `SPQ_ASSERT_NOW(a_full_count, (state_r == S_RES) && (res_r.status == spq_pkg::STATUS_FULL), count_r == CNT_W'(spq_pkg::CAPACITY), "full status with queue not full")
  `SPQ_ASSERT_NEXT(a_pop_count, (state_r == S_CMP) && deq_r, (count_r + CNT_W'(1)) == $past(count_r), "pop did not drop count by one")
  `SPQ_ASSERT_NOW(a_wr_state, wr.en, (state_r == S_READ) || (state_r == S_CMP), "store write outside walk")
  `SPQ_ASSERT_NEXT(a_accept_busy, in_chan.valid && in_chan.ready, state_r != S_IDLE, "accepted transaction left sequencer idle")

endmodule

>>> tb/sorted_priority_queue_core_tb.sv
// testbench for the sorted priority queue core: directed and random enqueue/dequeue traffic
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;
  import spq_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CALM_TAIL    = 250;
  localparam int PRINT_CAP    = 40;

  // one queued request for the driver
  typedef struct {
    logic                cmd;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
    bit                  drain_first;
  } queue_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  spq_in_if  in_chan ();
  spq_out_if out_chan ();

  sorted_priority_queue_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  queue_req_t  pending_reqs[$];
  spq_result_t results_due[$];

  // shadow copy of the queue contents, head at slot 0
  logic [KEY_BITS-1:0] shadow_keys [CAPACITY];
  logic [TAG_BITS-1:0] shadow_tags [CAPACITY];
  int unsigned         shadow_depth = 0;

  bit req_taken  = 1'b0;
  int send_hold  = 0;
  int sink_hold  = 0;
  int cycles     = 0;
  int mismatches = 0;
  int results_seen = 0;
  int enq_ok = 0, enq_full = 0, deq_ok = 0, deq_empty = 0, peak_depth = 0;

  // apply one command to the shadow queue and return the result it must give
  function automatic spq_result_t queue_apply(logic cmd, logic [KEY_BITS-1:0] key,
                                              logic [TAG_BITS-1:0] tag);
    spq_result_t r;
    int unsigned slot;
    int unsigned i;
    r = '0;
    r.status = STATUS_OK;
    if (cmd == CMD_DEQ) begin
      if (shadow_depth == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.key = shadow_keys[0];
        r.tag = shadow_tags[0];
        for (i = 1; i < shadow_depth; i++) begin
          shadow_keys[i-1] = shadow_keys[i];
          shadow_tags[i-1] = shadow_tags[i];
        end
        shadow_depth--;
      end
    end else if (shadow_depth >= CAPACITY) begin
      r.status = STATUS_FULL;
    end else begin
      // behind every entry with a greater or equal key
      slot = 0;
      while (slot < shadow_depth && shadow_keys[slot] >= key) slot++;
      for (i = shadow_depth; i > slot; i--) begin
        shadow_keys[i] = shadow_keys[i-1];
        shadow_tags[i] = shadow_tags[i-1];
      end
      shadow_keys[slot] = key;
      shadow_tags[slot] = tag;
      shadow_depth++;
    end
    r.count = CNT_W'(shadow_depth);
    return r;
  endfunction

  function automatic void queue_req(logic cmd, int key, int tag, bit drain_first);
    queue_req_t q;
    q.cmd         = cmd;
    q.key         = KEY_BITS'(key);
    q.tag         = TAG_BITS'(tag);
    q.drain_first = drain_first;
    pending_reqs.push_back(q);
  endfunction

  // idling level by position in the run: none, light or heavy, none at the tail
  function automatic int idle_level();
    if (pending_reqs.size() < CALM_TAIL) return 0;
    return (pending_reqs.size() / 150) % 3;
  endfunction

  function automatic bit start_idle();
    int lvl;
    lvl = idle_level();
    return lvl != 0 && $urandom_range(0, 7) < ((lvl == 2) ? 4 : 1);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] result %0d: %s is %0d, expected %0d", $time, results_seen, field, got,
               want);
  endtask

  // request driver: new transaction or idle burst at the falling edge
  always @(negedge clk) begin : request_driver
    logic       vld;
    queue_req_t cur;
    vld = in_chan.valid;
    if (!rst_n) begin
      vld = 1'b0;
    end else begin
      if (req_taken) begin
        vld = 1'b0;
        req_taken = 1'b0;
      end
      if (!vld) begin
        if (send_hold > 0) begin
          send_hold--;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain_first && results_due.size() != 0)) begin
          cur = pending_reqs.pop_front();
          in_chan.cmd    <= cur.cmd;
          in_chan.key_in <= cur.key;
          in_chan.tag_in <= cur.tag;
          vld = 1'b1;
          if (start_idle()) send_hold = $urandom_range(1, 12);
        end
      end
    end
    in_chan.valid <= vld;
  end

  // accepted request: work out the result it must give
  always @(posedge clk) begin : request_tap
    spq_result_t due;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      due = queue_apply(in_chan.cmd, in_chan.key_in, in_chan.tag_in);
      results_due.push_back(due);
      req_taken = 1'b1;
      case (due.status)
        STATUS_EMPTY: deq_empty++;
        STATUS_FULL:  enq_full++;
        default: begin
          if (in_chan.cmd == CMD_DEQ) deq_ok++;
          else enq_ok++;
        end
      endcase
      if (shadow_depth > peak_depth) peak_depth = shadow_depth;
    end
  end

  // result sink: back-pressure in random bursts
  always @(negedge clk) begin : result_sink
    logic rdy;
    rdy = 1'b1;
    if (!rst_n) begin
      rdy = 1'b0;
    end else if (sink_hold > 0) begin
      rdy = 1'b0;
      sink_hold--;
    end else if (start_idle()) begin
      rdy = 1'b0;
      sink_hold = $urandom_range(1, 12) - 1;
    end
    out_chan.ready <= rdy;
  end

  // result monitor and watchdog
  always @(posedge clk) begin : result_monitor
    spq_result_t want;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("[%0t] watchdog expired with %0d results outstanding", $time,
               results_due.size());
      $display("sorted_priority_queue_core_tb: done, errors");
      $finish;
    end else if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result, status", int'(out_chan.status), -1);
      end else begin
        want = results_due.pop_front();
        if (out_chan.status !== want.status)
          report_mismatch("status", int'(out_chan.status), int'(want.status));
        if (out_chan.key_out !== want.key)
          report_mismatch("key_out", int'(out_chan.key_out), int'(want.key));
        if (out_chan.tag_out !== want.tag)
          report_mismatch("tag_out", int'(out_chan.tag_out), int'(want.tag));
        if (out_chan.count !== want.count)
          report_mismatch("count", int'(out_chan.count), int'(want.count));
      end
    end
  end

  initial begin
    int   kind, run, span, base, j, key, n_random;
    logic cmd;

    in_chan.valid  = 1'b0;
    in_chan.cmd    = CMD_ENQ;
    in_chan.key_in = '0;
    in_chan.tag_in = '0;
    out_chan.ready = 1'b0;

    // directed: empty dequeue, extremes, equal keys, ties at the smallest key, full queue
    queue_req(CMD_DEQ, 1023, 255, 1'b0);
    queue_req(CMD_ENQ, 1023, 255, 1'b0);
    queue_req(CMD_ENQ, 0, 0, 1'b0);
    queue_req(CMD_ENQ, 512, 'hA5, 1'b0);
    queue_req(CMD_ENQ, 512, 'h5A, 1'b0);
    queue_req(CMD_ENQ, 512, 'h3C, 1'b0);
    queue_req(CMD_ENQ, 0, 'h01, 1'b0);
    queue_req(CMD_ENQ, 1, 'h02, 1'b0);
    queue_req(CMD_ENQ, 1022, 'h03, 1'b0);
    queue_req(CMD_ENQ, 700, 'h04, 1'b0);
    queue_req(CMD_ENQ, 300, 'h05, 1'b0);
    queue_req(CMD_ENQ, 511, 'h06, 1'b0);
    queue_req(CMD_ENQ, 513, 'h07, 1'b0);
    queue_req(CMD_ENQ, 2, 'h08, 1'b0);
    queue_req(CMD_ENQ, 1023, 'h80, 1'b0);
    queue_req(CMD_ENQ, 0, 'hFF, 1'b0);
    queue_req(CMD_ENQ, 256, 'h81, 1'b0);
    queue_req(CMD_ENQ, 1023, 255, 1'b0);
    for (j = 0; j < 4; j++) queue_req(CMD_DEQ, 0, 0, 1'b0);

    // random runs: fill, drain or mixed, keys spread, clustered or ordered
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      run  = $urandom_range(1, 20);
      span = $urandom_range(0, 3);
      base = $urandom_range(0, 1023);
      for (j = 0; j < run; j++) begin
        if (kind <= 3) cmd = ($urandom_range(0, 9) == 0) ? CMD_DEQ : CMD_ENQ;
        else if (kind <= 6) cmd = ($urandom_range(0, 9) == 0) ? CMD_ENQ : CMD_DEQ;
        else cmd = $urandom_range(0, 1) ? CMD_DEQ : CMD_ENQ;
        case (span)
          0: key = $urandom_range(0, 1023);
          1: key = (base & ~3) | $urandom_range(0, 3);
          2: key = base + j * 7;
          default: key = base - j * 7;
        endcase
        // sender waits for an empty pipeline every 500 items
        queue_req(cmd, key & 1023, $urandom_range(0, 255), (n_random % 500) == 0);
        n_random++;
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_reqs.size() != 0 || in_chan.valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d enqueues (%0d refused as full) and %0d dequeues (%0d on empty)",
             enq_ok + enq_full, enq_full, deq_ok + deq_empty, deq_empty);
    $display("queue depth reached %0d; %0d results checked, %0d mismatches", peak_depth,
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("sorted_priority_queue_core_tb: done, clean");
    end else begin
      $display("sorted_priority_queue_core_tb: done, errors");
    end
    $finish;
  end

endmodule
